// ----- rtl/srtf_preemptive_scheduler_macros.svh -----
// ----------------------------------------------------------------------------
// srtf scheduler assertion macros
// shared property wrappers for the scheduler checks
// ----------------------------------------------------------------------------
`ifndef SRTF_PREEMPTIVE_SCHEDULER_MACROS_SVH
`define SRTF_PREEMPTIVE_SCHEDULER_MACROS_SVH

// same-cycle implication under synchronous reset
`define SRTF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous reset
`define SRTF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/srtf_pkg.sv -----
// ----------------------------------------------------------------------------
// srtf scheduler package
// word types, cell hand-over types and shared constants
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srtf_pkg;

    localparam int MAX_PROCS_DEF = 16;
    localparam int TIME_BITS_DEF = 16;

    localparam int  CNT_W    = 5;
    localparam logic [CNT_W-1:0] DONE_MAX = 5'd31;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [3:0]  slot;
        logic [15:0] proc_id;
        logic [15:0] arrival;
        logic [15:0] burst;
    } t_in;

    typedef struct packed {
        logic [15:0] tick_time;
        logic        idle;
        logic [3:0]  run_slot;
        logic [15:0] run_id;
        logic        new_block;
        logic        first_run;
        logic [15:0] begin_time;
        logic        finished;
        logic [15:0] finish_time;
        logic [15:0] turnaround;
        logic        all_done;
    } t_out;

    // best candidate so far, handed from cell to cell
    typedef struct packed {
        logic        found;
        logic [15:0] rem;
        logic [15:0] arr;
        logic [15:0] id;
        logic        started;
        logic [15:0] start;
    } t_cand;

    typedef struct packed {
        logic        en;
        logic [3:0]  slot;
        logic [15:0] id;
        logic [15:0] arr;
        logic [15:0] burst;
    } t_load;

    typedef struct packed {
        logic        en;
        logic [15:0] now;
    } t_commit;

endpackage

`default_nettype wire

// ----- rtl/srtf_cell.sv -----
// ----------------------------------------------------------------------------
// srtf scheduler cell
// holds one process slot and folds it into the best candidate passing by
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srtf_cell #(
    parameter int IDX       = 0,
    parameter int MAX_PROCS = srtf_pkg::MAX_PROCS_DEF,
    parameter int TIME_BITS = srtf_pkg::TIME_BITS_DEF,
    localparam int SW       = $clog2(MAX_PROCS)
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire [srtf_pkg::CNT_W-1:0]    i_n_eff,
    input  wire [TIME_BITS-1:0]          i_now,
    input  srtf_pkg::t_load              i_load,
    input  srtf_pkg::t_commit            i_commit,
    input  wire [SW-1:0]                 i_commit_slot,
    input  wire                          i_valid,
    input  srtf_pkg::t_cand              i_cand,
    input  wire [SW-1:0]                 i_slot,
    output logic                         o_valid,
    output srtf_pkg::t_cand              o_cand,
    output logic [SW-1:0]                o_slot
);

    logic [15:0] r_id;
    logic [15:0] r_arr;
    logic [15:0] r_rem;
    logic        r_started;
    logic [15:0] r_start;

    logic            r_valid;
    srtf_pkg::t_cand r_cand;
    logic [SW-1:0]   r_slot;

    srtf_pkg::t_cand self_cand;
    logic            self_ok;
    logic            take_self;
    logic            load_hit;
    logic            commit_hit;

    assign load_hit   = i_load.en && (32'(i_load.slot) == IDX);
    assign commit_hit = i_commit.en && (i_commit_slot == SW'(IDX));

    always_comb begin
        self_cand.found   = 1'b1;
        self_cand.rem     = r_rem;
        self_cand.arr     = r_arr;
        self_cand.id      = r_id;
        self_cand.started = r_started;
        self_cand.start   = r_start;
        self_ok = (32'(i_n_eff) > IDX) && (r_rem != 16'd0) &&
                  !(32'(r_arr) > 32'(i_now));
        // ties on remaining time go to the earlier arrival, then the lower slot
        take_self = self_ok && (!i_cand.found || (r_rem < i_cand.rem) ||
                    ((r_rem == i_cand.rem) && (r_arr < i_cand.arr)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem     <= '0;
            r_started <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= i_valid;
            if (load_hit) begin
                r_rem     <= i_load.burst;
                r_started <= 1'b0;
            end else if (commit_hit) begin
                r_rem <= r_rem - 16'd1;
                if (!r_started) begin
                    r_started <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_hit) begin
            r_id  <= i_load.id;
            r_arr <= i_load.arr;
        end
        if (commit_hit && !r_started) begin
            r_start <= i_commit.now;
        end
        if (take_self) begin
            r_cand <= self_cand;
            r_slot <= SW'(IDX);
        end else begin
            r_cand <= i_cand;
            r_slot <= i_slot;
        end
    end

    assign o_valid = r_valid;
    assign o_cand  = r_cand;
    assign o_slot  = r_slot;

endmodule

`default_nettype wire

// ----- rtl/srtf_preemptive_scheduler.sv -----
// ----------------------------------------------------------------------------
// srtf preemptive scheduler
// shortest-remaining-time-first over a row of slot cells
// ----------------------------------------------------------------------------
// a load word is taken while idle and gives no result.
// a tick word sends a candidate along MAX_PROCS cells, one cell per cycle;
// its result strobes after the launch register, the cell row and the result register.
// a new word is taken only once the previous tick has left the cell row.
// busy stays high from the tick until its result; the receiver cannot stall.
// synchronous active-low reset clears times, counts, remaining times and flags.
`timescale 1ns / 1ps
`default_nettype none
`include "srtf_preemptive_scheduler_macros.svh"

module srtf_preemptive_scheduler #(
    parameter int MAX_PROCS = srtf_pkg::MAX_PROCS_DEF,
    parameter int TIME_BITS = srtf_pkg::TIME_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  srtf_pkg::t_in                i_item,
    input  wire                          i_cfg_we,
    input  wire [srtf_pkg::CNT_W-1:0]    i_cfg_data,
    output logic                         o_strobe,
    output srtf_pkg::t_out               o_result
);

    localparam int SW = $clog2(MAX_PROCS);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [srtf_pkg::CNT_W-1:0] r_num_procs;
    logic [srtf_pkg::CNT_W-1:0] n_eff;
    logic [TIME_BITS-1:0]       r_time;
    logic [TIME_BITS-1:0]       fin;
    logic [SW-1:0]              r_last_slot;
    logic                       r_last_valid;
    logic [srtf_pkg::CNT_W-1:0] r_done, n_done;
    logic                       r_launch;
    logic                       r_strobe;
    srtf_pkg::t_out             r_result, n_result;

    logic                       accept;
    logic                       tail_valid;
    logic                       finish_now;
    srtf_pkg::t_cand            tail;
    logic [SW-1:0]              tail_slot;
    srtf_pkg::t_load            load;
    srtf_pkg::t_commit          commit;

    logic                       v_valid [MAX_PROCS+1];
    srtf_pkg::t_cand            v_cand  [MAX_PROCS+1];
    logic [SW-1:0]              v_slot  [MAX_PROCS+1];
    logic [MAX_PROCS:0]         valid_vec;

    assign busy   = (r_state == ST_SCAN);
    assign accept = start && !busy;

    // a register value above the slot count counts as the slot count
    assign n_eff = (32'(r_num_procs) > MAX_PROCS) ? srtf_pkg::CNT_W'(MAX_PROCS)
                                                  : r_num_procs;

    always_comb begin
        load.en    = accept && (i_item.cmd == srtf_pkg::CMD_LOAD);
        load.slot  = i_item.slot;
        load.id    = i_item.proc_id;
        load.arr   = i_item.arrival;
        load.burst = i_item.burst;
    end

    assign v_valid[0] = r_launch;
    assign v_cand[0]  = '0;
    assign v_slot[0]  = '0;

    generate
        for (genvar k = 0; k < MAX_PROCS; k++) begin : g_cell
            srtf_cell #(
                .IDX       (k),
                .MAX_PROCS (MAX_PROCS),
                .TIME_BITS (TIME_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_n_eff       (n_eff),
                .i_now         (r_time),
                .i_load        (load),
                .i_commit      (commit),
                .i_commit_slot (tail_slot),
                .i_valid       (v_valid[k]),
                .i_cand        (v_cand[k]),
                .i_slot        (v_slot[k]),
                .o_valid       (v_valid[k+1]),
                .o_cand        (v_cand[k+1]),
                .o_slot        (v_slot[k+1])
            );
        end
        for (genvar j = 0; j <= MAX_PROCS; j++) begin : g_vec
            assign valid_vec[j] = v_valid[j];
        end
    endgenerate

    assign tail_valid = v_valid[MAX_PROCS];
    assign tail       = v_cand[MAX_PROCS];
    assign tail_slot  = v_slot[MAX_PROCS];

    assign fin        = r_time + TIME_BITS'(1);
    assign finish_now = tail.found && (tail.rem == 16'd1);

    always_comb begin
        commit.en  = tail_valid && tail.found;
        commit.now = 16'(r_time);
    end

    always_comb begin
        n_done = r_done;
        if (finish_now && (r_done != srtf_pkg::DONE_MAX)) begin
            n_done = r_done + srtf_pkg::CNT_W'(1);
        end
        n_result           = '0;
        n_result.tick_time = 16'(r_time);
        n_result.idle      = !tail.found;
        if (tail.found) begin
            n_result.run_slot   = 4'(tail_slot);
            n_result.run_id     = tail.id;
            n_result.new_block  = !r_last_valid || (r_last_slot != tail_slot);
            n_result.first_run  = !tail.started;
            n_result.begin_time = tail.started ? tail.start : 16'(r_time);
            if (finish_now) begin
                n_result.finished    = 1'b1;
                n_result.finish_time = 16'(fin);
                n_result.turnaround  = 16'(fin - TIME_BITS'(tail.arr));
            end
        end
        n_result.all_done = (n_done >= n_eff);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_item.cmd == srtf_pkg::CMD_TICK)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (tail_valid) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_num_procs  <= '0;
            r_time       <= '0;
            r_last_slot  <= '0;
            r_last_valid <= 1'b0;
            r_done       <= '0;
            r_launch     <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= accept && (i_item.cmd == srtf_pkg::CMD_TICK);
            r_strobe <= tail_valid;
            if (i_cfg_we) begin
                r_num_procs <= i_cfg_data;
            end
            if (tail_valid) begin
                r_time       <= fin;
                r_last_valid <= tail.found;
                r_done       <= n_done;
                if (tail.found) begin
                    r_last_slot <= tail_slot;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tail_valid) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // only one candidate word travels the row at a time
    `SRTF_ASSERT_NOW(a_one_token, i_clk, i_rst_n, 1'b1, $onehot0(valid_vec),
        "more than one candidate in the cell row")
    `SRTF_ASSERT_NOW(a_idle_empty, i_clk, i_rst_n, !busy, valid_vec[MAX_PROCS:1] == '0,
        "candidate in the cell row while not busy")
    `SRTF_ASSERT_NEXT(a_tail_result, i_clk, i_rst_n, busy && tail_valid,
        o_strobe && !busy, "row tail did not produce a result")
    `SRTF_ASSERT_NOW(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy && $past(busy),
        "result strobe outside the end of a tick")

endmodule

`default_nettype wire
